// File: hdl/ac3_frame_header_parser_assert.svh
// Assertion macros for the AC-3 header parser.
// No dependencies; included by the top level.
`ifndef AC3_FRAME_HEADER_PARSER_ASSERT_SVH
`define AC3_FRAME_HEADER_PARSER_ASSERT_SVH
// implication checked every clock outside reset
`define AHP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define AHP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/ahp_pkg.sv
// Package for the AC-3 header parser: field step codes, width and channel tables.
// No dependencies.
`default_nettype none
package ahp_pkg;
  localparam logic [5:0] ST_SYNC = 6'd0;
  localparam logic [5:0] ST_CRC1 = 6'd1;
  localparam logic [5:0] ST_FSCOD = 6'd2;
  localparam logic [5:0] ST_FRMSIZ = 6'd3;
  localparam logic [5:0] ST_BSID = 6'd4;
  localparam logic [5:0] ST_BSMOD = 6'd5;
  localparam logic [5:0] ST_ACMOD = 6'd6;
  localparam logic [5:0] ST_CMIX = 6'd7;
  localparam logic [5:0] ST_SURMIX = 6'd8;
  localparam logic [5:0] ST_DSUR = 6'd9;
  localparam logic [5:0] ST_LFEON = 6'd10;
  localparam logic [5:0] ST_NBCH = 6'd11;
  localparam logic [5:0] ST_DIALNORM = 6'd12;
  localparam logic [5:0] ST_COMPRE = 6'd13;
  localparam logic [5:0] ST_COMPR = 6'd14;
  localparam logic [5:0] ST_LANGCODE = 6'd15;
  localparam logic [5:0] ST_LANGCOD = 6'd16;
  localparam logic [5:0] ST_AUDPRODIE = 6'd17;
  localparam logic [5:0] ST_MIXLEVEL = 6'd18;
  localparam logic [5:0] ST_ROOMTYP = 6'd19;
  localparam logic [5:0] ST_DIALNORM2 = 6'd20;
  localparam logic [5:0] ST_COMPR2E = 6'd21;
  localparam logic [5:0] ST_COMPR2 = 6'd22;
  localparam logic [5:0] ST_LANGCOD2E = 6'd23;
  localparam logic [5:0] ST_LANGCOD2 = 6'd24;
  localparam logic [5:0] ST_AUDPRODI2E = 6'd25;
  localparam logic [5:0] ST_MIXLEVEL2 = 6'd26;
  localparam logic [5:0] ST_ROOMTYP2 = 6'd27;
  localparam logic [5:0] ST_COPYRIGHTB = 6'd28;
  localparam logic [5:0] ST_ORIGBS = 6'd29;
  localparam logic [5:0] ST_XBSI1E = 6'd30;
  localparam logic [5:0] ST_DMIXMOD = 6'd31;
  localparam logic [5:0] ST_LTRTC = 6'd32;
  localparam logic [5:0] ST_LTRTS = 6'd33;
  localparam logic [5:0] ST_LOROC = 6'd34;
  localparam logic [5:0] ST_LOROS = 6'd35;
  localparam logic [5:0] ST_XBSI2E = 6'd36;
  localparam logic [5:0] ST_DSUREX = 6'd37;
  localparam logic [5:0] ST_DHEADPHON = 6'd38;
  localparam logic [5:0] ST_ADCONV = 6'd39;
  localparam logic [5:0] ST_XBSI2 = 6'd40;
  localparam logic [5:0] ST_ENCINFO = 6'd41;
  localparam logic [5:0] ST_TIMECOD1E = 6'd42;
  localparam logic [5:0] ST_TIMECOD1 = 6'd43;
  localparam logic [5:0] ST_TIMECOD2E = 6'd44;
  localparam logic [5:0] ST_TIMECOD2 = 6'd45;
  localparam logic [5:0] ST_ADDBSIE = 6'd46;
  localparam logic [5:0] ST_ADDBSIL = 6'd47;
  localparam logic [5:0] ST_EXTWORD = 6'd48;
  localparam logic [5:0] ST_SKIP = 6'd49;
  localparam logic [5:0] ST_DONE = 6'd50;

  localparam logic [15:0] SYNC_WORD = 16'h0B77;
  localparam logic [4:0] BSID_MAX = 5'd8;
  localparam logic [4:0] BSID_ALT = 5'd6;
  localparam logic [7:0] EXT_TYPE_A = 8'h01;

  localparam logic [2:0] STAT_FIELD = 3'd0;
  localparam logic [2:0] STAT_DONE = 3'd1;
  localparam logic [2:0] STAT_BAD_SYNC = 3'd2;
  localparam logic [2:0] STAT_BAD_BSID = 3'd3;
  localparam logic [2:0] STAT_TRUNC = 3'd4;

  // result word handed from the parser core to the output queue
  typedef struct packed {
    logic [5:0] code;
    logic [15:0] value;
    logic [2:0] status;
  } result_t;

  // field width per step; zero ends parsing
  function automatic logic [4:0] field_width(input logic [5:0] s);
    logic [4:0] w;
    case (s)
      ST_SYNC, ST_CRC1, ST_TIMECOD1, ST_TIMECOD2, ST_EXTWORD: w = 5'd16;
      ST_FSCOD, ST_CMIX, ST_SURMIX, ST_DSUR, ST_ROOMTYP, ST_ROOMTYP2, ST_DMIXMOD,
      ST_DSUREX, ST_DHEADPHON: w = 5'd2;
      ST_FRMSIZ, ST_ADDBSIL: w = 5'd6;
      ST_BSID, ST_DIALNORM, ST_MIXLEVEL, ST_DIALNORM2, ST_MIXLEVEL2: w = 5'd5;
      ST_BSMOD, ST_ACMOD, ST_LTRTC, ST_LTRTS, ST_LOROC, ST_LOROS: w = 5'd3;
      ST_COMPR, ST_LANGCOD, ST_COMPR2, ST_LANGCOD2, ST_XBSI2, ST_SKIP: w = 5'd8;
      ST_LFEON, ST_COMPRE, ST_LANGCODE, ST_AUDPRODIE, ST_COMPR2E, ST_LANGCOD2E,
      ST_AUDPRODI2E, ST_COPYRIGHTB, ST_ORIGBS, ST_XBSI1E, ST_XBSI2E, ST_ADCONV,
      ST_ENCINFO, ST_TIMECOD1E, ST_TIMECOD2E, ST_ADDBSIE: w = 5'd1;
      default: w = 5'd0;
    endcase
    return w;
  endfunction

  // base channel count by acmod
  function automatic logic [2:0] chan_count(input logic [2:0] a);
    logic [2:0] c;
    case (a)
      3'd1: c = 3'd1;
      3'd0, 3'd2: c = 3'd2;
      3'd3, 3'd4: c = 3'd3;
      3'd5, 3'd6: c = 3'd4;
      default: c = 3'd5;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

// File: hdl/ahp_core.sv
// Bit-serial parser core: while in its bit state, shifts one bit a cycle into a shared
// collector and walks the syncinfo/bsi field sequence. Uses ahp_pkg.
`default_nettype none
module ahp_core (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic [7:0] byte_in,
  input wire logic fend_in,
  output ahp_pkg::result_t res0,
  output ahp_pkg::result_t res1,
  output logic [1:0] res_cnt,
  output logic res_last,
  output logic busy
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_BIT = 4'b0010,
    S_END = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  logic [7:0] sh;
  logic [2:0] bit_idx;
  logic fend;
  logic [5:0] field_step;
  logic [15:0] bit_collector;
  logic [4:0] bits_held;
  logic [4:0] stream_id_seen;
  logic [2:0] channel_mode_seen;
  logic [6:0] skip_bytes_left;
  logic idle_until_end;

  logic [4:0] w;
  logic [15:0] v;
  logic done_bit;
  logic [5:0] nx, rs;
  logic [5:0] step_n;
  logic [4:0] sid_n;
  logic [2:0] cm_n;
  logic [6:0] skip_n;
  logic idle_n;
  logic [1:0] cnt_n;
  ahp_pkg::result_t r0_n, r1_n;

  assign busy = (state != S_IDLE);
  assign res_last = (state == S_FLUSH);

  // one bit of field parsing
  always_comb begin
    w = ahp_pkg::field_width(field_step);
    v = {bit_collector[14:0], sh[7]};
    done_bit = ((bits_held + 5'd1) >= w);
    step_n = field_step;
    sid_n = stream_id_seen;
    cm_n = channel_mode_seen;
    skip_n = skip_bytes_left;
    idle_n = idle_until_end;
    cnt_n = 2'd0;
    r0_n = '{code: field_step, value: v, status: ahp_pkg::STAT_FIELD};
    r1_n = '{code: 6'd0, value: 16'd0, status: ahp_pkg::STAT_DONE};
    nx = field_step + 6'd1;
    rs = 6'd0;
    if (w == 5'd0) begin
      idle_n = 1'b1;
    end else if (done_bit) begin
      cnt_n = 2'd1;
      case (field_step)
        ahp_pkg::ST_SYNC: if (v != ahp_pkg::SYNC_WORD) begin
          r0_n.status = ahp_pkg::STAT_BAD_SYNC;
          idle_n = 1'b1;
        end
        ahp_pkg::ST_BSID: if (v[4:0] > ahp_pkg::BSID_MAX) begin
          r0_n.status = ahp_pkg::STAT_BAD_BSID;
          idle_n = 1'b1;
        end else begin
          sid_n = v[4:0];
        end
        ahp_pkg::ST_ACMOD: cm_n = v[2:0];
        ahp_pkg::ST_LFEON: begin
          cnt_n = 2'd2;
          r1_n = '{code: ahp_pkg::ST_NBCH,
                   value: {13'd0, ahp_pkg::chan_count(channel_mode_seen)} + {15'd0, v[0]},
                   status: ahp_pkg::STAT_FIELD};
          nx = ahp_pkg::ST_DIALNORM;
        end
        ahp_pkg::ST_COMPRE: nx = v[0] ? ahp_pkg::ST_COMPR : ahp_pkg::ST_LANGCODE;
        ahp_pkg::ST_LANGCODE: nx = v[0] ? ahp_pkg::ST_LANGCOD : ahp_pkg::ST_AUDPRODIE;
        ahp_pkg::ST_AUDPRODIE: nx = v[0] ? ahp_pkg::ST_MIXLEVEL : ahp_pkg::ST_DIALNORM2;
        ahp_pkg::ST_COMPR2E: nx = v[0] ? ahp_pkg::ST_COMPR2 : ahp_pkg::ST_LANGCOD2E;
        ahp_pkg::ST_LANGCOD2E: nx = v[0] ? ahp_pkg::ST_LANGCOD2 : ahp_pkg::ST_AUDPRODI2E;
        ahp_pkg::ST_AUDPRODI2E: nx = v[0] ? ahp_pkg::ST_MIXLEVEL2 : ahp_pkg::ST_COPYRIGHTB;
        ahp_pkg::ST_XBSI1E: nx = v[0] ? ahp_pkg::ST_DMIXMOD : ahp_pkg::ST_XBSI2E;
        ahp_pkg::ST_XBSI2E: nx = v[0] ? ahp_pkg::ST_DSUREX : ahp_pkg::ST_ADDBSIE;
        ahp_pkg::ST_ENCINFO: nx = ahp_pkg::ST_ADDBSIE;
        ahp_pkg::ST_TIMECOD1E: nx = v[0] ? ahp_pkg::ST_TIMECOD1 : ahp_pkg::ST_TIMECOD2E;
        ahp_pkg::ST_TIMECOD2E: nx = v[0] ? ahp_pkg::ST_TIMECOD2 : ahp_pkg::ST_ADDBSIE;
        ahp_pkg::ST_ADDBSIE: nx = v[0] ? ahp_pkg::ST_ADDBSIL : ahp_pkg::ST_DONE;
        ahp_pkg::ST_ADDBSIL: begin
          if (v[5:0] == 6'd1) begin
            nx = ahp_pkg::ST_EXTWORD;
          end else begin
            nx = ahp_pkg::ST_SKIP;
            skip_n = {1'b0, v[5:0]} + 7'd1;
          end
        end
        ahp_pkg::ST_EXTWORD: begin
          idle_n = 1'b1;
          if (v[15:8] == ahp_pkg::EXT_TYPE_A) begin
            r0_n.value = {8'd0, v[7:0]};
            cnt_n = 2'd2;
          end else begin
            r0_n = r1_n;
            cnt_n = 2'd1;
          end
        end
        ahp_pkg::ST_SKIP: begin
          skip_n = skip_bytes_left - 7'd1;
          cnt_n = 2'd0;
          if (skip_n == 7'd0) begin
            r0_n = r1_n;
            cnt_n = 2'd1;
            idle_n = 1'b1;
          end
        end
        default: ;
      endcase
      // presence rules
      rs = nx;
      if (rs == ahp_pkg::ST_CMIX && !(cm_n[0] && cm_n != 3'd1)) rs = ahp_pkg::ST_SURMIX;
      if (rs == ahp_pkg::ST_SURMIX && !cm_n[2]) rs = ahp_pkg::ST_DSUR;
      if (rs == ahp_pkg::ST_DSUR && cm_n != 3'd2) rs = ahp_pkg::ST_LFEON;
      if (rs == ahp_pkg::ST_DIALNORM2 && cm_n != 3'd0) rs = ahp_pkg::ST_COPYRIGHTB;
      if (rs == ahp_pkg::ST_XBSI1E && sid_n != ahp_pkg::BSID_ALT)
        rs = ahp_pkg::ST_TIMECOD1E;
      if (!idle_n && field_step != ahp_pkg::ST_SKIP) begin
        if (field_step == ahp_pkg::ST_LFEON) begin
          step_n = nx;
        end else if (rs == ahp_pkg::ST_DONE) begin
          cnt_n = 2'd2;
          idle_n = 1'b1;
        end else begin
          step_n = rs;
        end
      end
    end
  end

  // sequencer: one bit per cycle in the bit state, an end step for frame end, then
  // a flush step that seals the byte's words in the queue for output
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      field_step <= ahp_pkg::ST_SYNC;
      bit_collector <= '0;
      bits_held <= '0;
      stream_id_seen <= '0;
      channel_mode_seen <= '0;
      skip_bytes_left <= '0;
      idle_until_end <= 1'b0;
      res_cnt <= '0;
      bit_idx <= '0;
      fend <= 1'b0;
    end else begin
      res_cnt <= 2'd0;
      case (state)
        S_IDLE: if (start) begin
          sh <= byte_in;
          fend <= fend_in;
          bit_idx <= 3'd0;
          state <= S_BIT;
        end
        S_BIT: begin
          if (!idle_until_end) begin
            if (w != 5'd0 && done_bit) begin
              bit_collector <= '0;
              bits_held <= '0;
            end else if (w != 5'd0) begin
              bit_collector <= v;
              bits_held <= bits_held + 5'd1;
            end
            field_step <= step_n;
            stream_id_seen <= sid_n;
            channel_mode_seen <= cm_n;
            skip_bytes_left <= skip_n;
            idle_until_end <= idle_n;
            res0 <= r0_n;
            res1 <= r1_n;
            res_cnt <= cnt_n;
          end
          sh <= {sh[6:0], 1'b0};
          bit_idx <= bit_idx + 3'd1;
          if (bit_idx == 3'd7) state <= S_END;
        end
        S_END: begin
          if (fend) begin
            if (!idle_until_end) begin
              res0 <= '{code: field_step, value: 16'd0, status: ahp_pkg::STAT_TRUNC};
              res_cnt <= 2'd1;
            end
            field_step <= ahp_pkg::ST_SYNC;
            bit_collector <= '0;
            bits_held <= '0;
            stream_id_seen <= '0;
            channel_mode_seen <= '0;
            skip_bytes_left <= '0;
            idle_until_end <= 1'b0;
          end
          state <= S_FLUSH;
        end
        S_FLUSH: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: hdl/ahp_outq.sv
// Result queue: holds results of the current byte and marks the final one.
// Uses ahp_pkg::result_t.
`default_nettype none
module ahp_outq (
  input wire logic clk,
  input wire logic rst,
  input wire ahp_pkg::result_t in0,
  input wire ahp_pkg::result_t in1,
  input wire logic [1:0] in_cnt,
  input wire logic in_flush,
  output ahp_pkg::result_t out_res,
  output logic out_last,
  output logic out_valid,
  input wire logic out_ready,
  output logic pending
);
  ahp_pkg::result_t mem [16];
  logic [3:0] wp, rp;
  logic [4:0] cnt;
  logic [4:0] batch;
  logic [4:0] marked;

  assign out_valid = (marked != 5'd0);
  assign out_res = mem[rp];
  assign out_last = (marked == 5'd1);
  assign pending = (cnt != 5'd0);

  // write up to two results a cycle; flush seals the byte's batch
  always_ff @(posedge clk) begin
    logic pop;
    logic [4:0] c;
    pop = out_valid && out_ready;
    c = batch;
    if (in_cnt != 2'd0) begin
      mem[wp] <= in0;
      if (in_cnt == 2'd2) mem[wp + 4'd1] <= in1;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
      batch <= '0;
      marked <= '0;
    end else begin
      wp <= wp + {2'd0, in_cnt};
      if (pop) rp <= rp + 4'd1;
      cnt <= cnt + {3'd0, in_cnt} - {4'd0, pop};
      c = batch + {3'd0, in_cnt};
      if (in_flush) begin
        marked <= c;
        batch <= '0;
      end else begin
        batch <= c;
        marked <= marked - {4'd0, pop};
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/ac3_frame_header_parser.sv
// Top level of the AC-3 syncinfo/bsi header parser.
// Uses ahp_pkg, ahp_core, ahp_outq and the assertion macro header.
//
// Input channel: one frame byte per word (data_byte, frame_end), valid/ready.
// Output channel: one result word per field (field_code, field_value, status,
// last_of_run), valid/ready; last_of_run marks the final word of a byte.
// After a byte is taken the core shifts it one bit at a time through the
// bit-serial shift/compare unit, then takes an end step for frame end and a
// flush step that releases the byte's words from the output queue together.
// Words become valid only after the flush step; a byte gives at most 12 words.
// The next byte is taken only after the previous byte's words are all
// delivered, so a stalled receiver holds off the input side.
// Reset (rst, synchronous) returns the parser to wait for a sync word and
// drops all queued words.
`default_nettype none
`include "ac3_frame_header_parser_assert.svh"
module ac3_frame_header_parser (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire logic [7:0] data_byte,
  input wire logic frame_end,
  output logic out_valid,
  input wire logic out_ready,
  output logic [5:0] field_code,
  output logic [15:0] field_value,
  output logic [2:0] status,
  output logic last_of_run
);
  ahp_pkg::result_t r0, r1, ro;
  logic [1:0] rcnt;
  logic rlast, busy, pending;

  assign in_ready = !busy && !pending;

  ahp_core u_core (
    .clk(clk), .rst(rst), .start(in_valid && in_ready),
    .byte_in(data_byte), .fend_in(frame_end),
    .res0(r0), .res1(r1), .res_cnt(rcnt), .res_last(rlast), .busy(busy)
  );

  ahp_outq u_q (
    .clk(clk), .rst(rst), .in0(r0), .in1(r1), .in_cnt(rcnt), .in_flush(rlast),
    .out_res(ro), .out_last(last_of_run), .out_valid(out_valid),
    .out_ready(out_ready), .pending(pending)
  );

  assign field_code = ro.code;
  assign field_value = ro.value;
  assign status = ro.status;

  `AHP_ASSERT_IMP(a_no_accept_busy, busy, !in_ready)
  `AHP_ASSERT_IMP(a_out_needs_pending, out_valid, pending)
  `AHP_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, busy)
endmodule
`default_nettype wire
